// File: rtl/nfa_pkg.sv
`default_nettype none

package nfa_pkg;

	// Widths fixed by the item and register fields
	localparam int unsigned SET_W     = 32;
	localparam int unsigned STATE_W   = 5;
	localparam int unsigned SYM_W     = 8;
	localparam int unsigned OP_W      = 2;
	localparam int unsigned CFG_IDX_W = 1;

	// Parameter defaults
	localparam int unsigned NUM_STATES_DEF  = 32;
	localparam int unsigned SYMBOL_BITS_DEF = 8;

	// Operation codes
	localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
	localparam logic [OP_W-1:0] OP_START = 2'd1;
	localparam logic [OP_W-1:0] OP_FEED  = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_START_STATE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_MASK = 1'b1;

	// Controller to datapath
	typedef struct packed {
		logic clr_step;
		logic load;
		logic rd_add;
		logic wr_add;
		logic scan_start;
		logic scan_step;
		logic set_start;
		logic commit;
		logic out_load;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic clr_last;
		logic scan_last;
	} dp_sts_t;

endpackage

`default_nettype wire

// File: rtl/nfa_ctrl.sv
`default_nettype none

module nfa_ctrl import nfa_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire logic [OP_W-1:0] operation,
	output logic                 in_stall,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output dp_cmd_t              cmd,
	input  wire dp_sts_t         sts
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RMW_RD,
		ST_RMW_WR,
		ST_START,
		ST_FEED,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;
	logic   out_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && (state_q == ST_IDLE);
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
			end
			ST_IDLE: begin
				cmd.load       = accept;
				cmd.scan_start = accept && (operation == OP_FEED);
			end
			ST_RMW_RD: begin
				cmd.rd_add = 1'b1;
			end
			ST_RMW_WR: begin
				cmd.wr_add = 1'b1;
			end
			ST_START: begin
				cmd.set_start = 1'b1;
			end
			ST_FEED: begin
				cmd.scan_step = 1'b1;
			end
			ST_DRAIN: begin
				cmd.commit = 1'b1;
			end
			ST_FINISH: begin
				cmd.out_load = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			// hold a waiting beat until the sink takes it
			out_valid_q <= ((state_q == ST_FINISH) && out_free) || (out_valid_q && out_stall);
			case (state_q)
				ST_CLEAR: begin
					if (sts.clr_last) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept) begin
						case (operation)
							OP_ADD:   state_q <= ST_RMW_RD;
							OP_START: state_q <= ST_START;
							OP_FEED:  state_q <= ST_FEED;
							default:  state_q <= ST_FINISH;
						endcase
					end
				end
				ST_RMW_RD: state_q <= ST_RMW_WR;
				ST_RMW_WR: state_q <= ST_FINISH;
				ST_START:  state_q <= ST_FINISH;
				ST_FEED: begin
					if (sts.scan_last) state_q <= ST_DRAIN;
				end
				ST_DRAIN: state_q <= ST_FINISH;
				ST_FINISH: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: rtl/nfa_dp.sv
`default_nettype none

module nfa_dp import nfa_pkg::*; #(
	parameter int unsigned NUM_STATES  = NUM_STATES_DEF,
	parameter int unsigned SYMBOL_BITS = SYMBOL_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire dp_cmd_t              cmd,
	output dp_sts_t                   sts,
	input  wire logic [STATE_W-1:0]   from_state,
	input  wire logic [SYM_W-1:0]     symbol,
	input  wire logic [STATE_W-1:0]   to_state,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [SET_W-1:0]     cfg_data,
	output logic [SET_W-1:0]          active_set,
	output logic                      accepted
);

	localparam int unsigned LIVE   = (NUM_STATES > SET_W) ? SET_W : NUM_STATES;
	localparam int unsigned ST_W   = $clog2(LIVE);
	localparam int unsigned ADDR_W = ST_W + SYMBOL_BITS;
	localparam int unsigned DEPTH  = 1 << ADDR_W;
	localparam logic [SET_W-1:0] LIVE_MASK =
		(LIVE == SET_W) ? {SET_W{1'b1}} : SET_W'((64'd1 << LIVE) - 64'd1);
	localparam logic [STATE_W:0]  LIVE_LIM  = (STATE_W+1)'(LIVE);
	localparam logic [ST_W-1:0]   SCAN_LAST = ST_W'(LIVE - 1);

	logic [SET_W-1:0]       mem [DEPTH];
	logic [SET_W-1:0]       rdata_q;

	logic [ADDR_W-1:0]      clr_q;
	logic [ST_W-1:0]        scan_q;
	logic                   step_s1;
	logic                   hit_s1;
	logic [SET_W-1:0]       next_q;
	logic [SET_W-1:0]       acc_d;

	logic [STATE_W-1:0]     from_q;
	logic [STATE_W-1:0]     to_q;
	logic [SYMBOL_BITS-1:0] sym_q;
	logic                   add_ok;

	logic [STATE_W-1:0]     start_q;
	logic [SET_W-1:0]       accept_q;
	logic [SET_W-1:0]       active_q;
	logic [SET_W-1:0]       out_set_q;
	logic                   out_acc_q;

	logic                   we;
	logic [ADDR_W-1:0]      waddr;
	logic [ADDR_W-1:0]      raddr;
	logic [ADDR_W-1:0]      add_addr;
	logic [SET_W-1:0]       wdata;

	assign add_ok   = ({1'b0, from_q} < LIVE_LIM) && ({1'b0, to_q} < LIVE_LIM);
	assign add_addr = {from_q[ST_W-1:0], sym_q};
	assign raddr    = cmd.rd_add ? add_addr : {scan_q, sym_q};
	assign we       = cmd.clr_step || (cmd.wr_add && add_ok);
	assign waddr    = cmd.clr_step ? clr_q : add_addr;
	assign wdata    = cmd.clr_step ? '0 : (rdata_q | (SET_W'(1) << to_q));

	assign sts.clr_last  = &clr_q;
	assign sts.scan_last = (scan_q == SCAN_LAST);

	assign acc_d = next_q | ((step_s1 && hit_s1) ? rdata_q : '0);

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q    <= '0;
			scan_q   <= '0;
			step_s1  <= 1'b0;
			start_q  <= '0;
			accept_q <= '0;
			active_q <= '0;
		end else begin
			if (cmd.clr_step) clr_q <= clr_q + 1'b1;

			if (cmd.scan_start)     scan_q <= '0;
			else if (cmd.scan_step) scan_q <= scan_q + 1'b1;
			step_s1 <= cmd.scan_step;

			if (cfg_we) begin
				case (cfg_index)
					CFG_START_STATE: start_q  <= cfg_data[STATE_W-1:0];
					CFG_ACCEPT_MASK: accept_q <= cfg_data;
					default: ;
				endcase
			end

			if (cmd.set_start) begin
				active_q <= ({1'b0, start_q} < LIVE_LIM) ? (SET_W'(1) << start_q) : '0;
			end else if (cmd.commit) begin
				active_q <= acc_d & LIVE_MASK;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			from_q <= from_state;
			to_q   <= to_state;
			sym_q  <= symbol[SYMBOL_BITS-1:0];
		end
		hit_s1 <= active_q[STATE_W'(scan_q)];
		// accumulate the entries of active states as their reads return
		if (cmd.scan_start)  next_q <= '0;
		else if (step_s1)    next_q <= acc_d;
		if (cmd.out_load) begin
			out_set_q <= active_q;
			out_acc_q <= |(active_q & accept_q);
		end
	end

	assign active_set = out_set_q;
	assign accepted   = out_acc_q;

endmodule

`default_nettype wire

// File: rtl/nfa_state_set_simulator.sv
`default_nettype none

// NFA active-set simulator without empty-symbol moves. After reset the transition
// store is swept to zero, one entry a cycle, over all 2**(clog2(min(NUM_STATES,32)) +
// SYMBOL_BITS) entries (8192 at the defaults); in_stall stays high meanwhile, while
// configuration writes are taken at once (cfg_ready is always high). start_run loads
// the active set from the start state, add_transition does a read-modify-write of one
// store entry, an unknown operation goes straight to its result beat, and feed_symbol
// steps the single store read port through every live state once; the result beat
// shows in the same cycle that the input opens again. One item is in work at a time;
// the next item is accepted while the previous result still waits in the output
// register.
module nfa_state_set_simulator import nfa_pkg::*; #(
	parameter int unsigned NUM_STATES  = NUM_STATES_DEF,
	parameter int unsigned SYMBOL_BITS = SYMBOL_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [OP_W-1:0]      operation,
	input  wire logic [STATE_W-1:0]   from_state,
	input  wire logic [SYM_W-1:0]     symbol,
	input  wire logic [STATE_W-1:0]   to_state,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [SET_W-1:0]          active_set,
	output logic                      accepted,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [SET_W-1:0]     cfg_data
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	assign cfg_ready = 1'b1;

	nfa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.operation (operation),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	nfa_dp #(
		.NUM_STATES  (NUM_STATES),
		.SYMBOL_BITS (SYMBOL_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.from_state (from_state),
		.symbol     (symbol),
		.to_state   (to_state),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.active_set (active_set),
		.accepted   (accepted)
	);

endmodule

`default_nettype wire

// File: rtl/nfa_chk.sv
`default_nettype none

module nfa_chk import nfa_pkg::*; (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             in_valid,
	input wire logic             in_stall,
	input wire logic             out_valid,
	input wire logic             out_stall,
	input wire logic [SET_W-1:0] active_set,
	input wire logic             accepted
);

	// one item in work at a time: busy right after a beat is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken again right after an accepted beat");

	// a result only appears out of a busy period
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared while the block was idle");

	// accepted needs at least one active state
	a_accept_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && accepted |-> active_set != '0)
		else $error("accepted with an empty active set");

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(active_set) && $stable(accepted))
		else $error("stalled result beat changed");

endmodule

bind nfa_state_set_simulator nfa_chk u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.active_set (active_set),
	.accepted   (accepted)
);

`default_nettype wire
